FILE: sv/sym3x3_matrix_inverse_top_macros.svh
// Assertion macros used by the sym3_chk checker.
`ifndef SYM3X3_MATRIX_INVERSE_TOP_MACROS_SVH
`define SYM3X3_MATRIX_INVERSE_TOP_MACROS_SVH

// Same-cycle implication.
`define SYM3_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sym3 check failed");

// Next-cycle implication.
`define SYM3_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sym3 check failed");

`endif

FILE: sv/sym3_pkg.sv
`timescale 1ns / 1ps
package sym3_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 24;
    localparam int N_LANES        = 6;

    typedef struct packed {
        logic neg;
        logic ovf;
        logic zero;
    } lane_flags_t;

endpackage

FILE: sv/sym3_cof.sv
`timescale 1ns / 1ps
module sym3_cof #(
    parameter int DW = 32
) (
    input  logic                   clk,
    input  logic [3:0]             en,
    input  logic signed [DW-1:0]   a,
    input  logic signed [DW-1:0]   b,
    input  logic signed [DW-1:0]   c,
    input  logic signed [DW-1:0]   e,
    input  logic signed [DW-1:0]   f,
    input  logic signed [DW-1:0]   g,
    output logic signed [2*DW:0]   c11,
    output logic signed [2*DW:0]   c12,
    output logic signed [2*DW:0]   c13,
    output logic signed [2*DW:0]   c22,
    output logic signed [2*DW:0]   c23,
    output logic signed [2*DW:0]   c33,
    output logic signed [3*DW+2:0] det
);
    import sym3_pkg::*;

    localparam int PW   = 2 * DW + 1;
    localparam int DETW = 3 * DW + 3;

    // stage 1: twelve products
    logic signed [2*DW-1:0] p_eg_reg, p_ff_reg, p_cf_reg, p_bg_reg, p_bf_reg, p_ec_reg;
    logic signed [2*DW-1:0] p_ag_reg, p_cc_reg, p_bc_reg, p_af_reg, p_ae_reg, p_bb_reg;
    logic signed [DW-1:0]   a1_reg, b1_reg, c1_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p_eg_reg <= e * g;
            p_ff_reg <= f * f;
            p_cf_reg <= c * f;
            p_bg_reg <= b * g;
            p_bf_reg <= b * f;
            p_ec_reg <= e * c;
            p_ag_reg <= a * g;
            p_cc_reg <= c * c;
            p_bc_reg <= b * c;
            p_af_reg <= a * f;
            p_ae_reg <= a * e;
            p_bb_reg <= b * b;
            a1_reg   <= a;
            b1_reg   <= b;
            c1_reg   <= c;
        end
    end

    // stage 2: cofactors
    logic signed [PW-1:0] c11_2_reg, c12_2_reg, c13_2_reg, c22_2_reg, c23_2_reg, c33_2_reg;
    logic signed [DW-1:0] a2_reg, b2_reg, c2_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            c11_2_reg <= PW'(p_eg_reg) - PW'(p_ff_reg);
            c12_2_reg <= PW'(p_cf_reg) - PW'(p_bg_reg);
            c13_2_reg <= PW'(p_bf_reg) - PW'(p_ec_reg);
            c22_2_reg <= PW'(p_ag_reg) - PW'(p_cc_reg);
            c23_2_reg <= PW'(p_bc_reg) - PW'(p_af_reg);
            c33_2_reg <= PW'(p_ae_reg) - PW'(p_bb_reg);
            a2_reg    <= a1_reg;
            b2_reg    <= b1_reg;
            c2_reg    <= c1_reg;
        end
    end

    // stage 3: determinant partial products, cofactor split in low and high halves
    logic signed [DW+1:0]   lo_a, lo_b, lo_c;
    logic signed [DW-1:0]   hi_a, hi_b, hi_c;
    logic signed [2*DW+1:0] pl_a_reg, pl_b_reg, pl_c_reg;
    logic signed [2*DW-1:0] ph_a_reg, ph_b_reg, ph_c_reg;
    logic signed [PW-1:0]   c11_3_reg, c12_3_reg, c13_3_reg, c22_3_reg, c23_3_reg, c33_3_reg;

    assign lo_a = $signed({1'b0, c11_2_reg[DW:0]});
    assign lo_b = $signed({1'b0, c12_2_reg[DW:0]});
    assign lo_c = $signed({1'b0, c13_2_reg[DW:0]});
    assign hi_a = c11_2_reg[PW-1:DW+1];
    assign hi_b = c12_2_reg[PW-1:DW+1];
    assign hi_c = c13_2_reg[PW-1:DW+1];

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            pl_a_reg  <= a2_reg * lo_a;
            pl_b_reg  <= b2_reg * lo_b;
            pl_c_reg  <= c2_reg * lo_c;
            ph_a_reg  <= a2_reg * hi_a;
            ph_b_reg  <= b2_reg * hi_b;
            ph_c_reg  <= c2_reg * hi_c;
            c11_3_reg <= c11_2_reg;
            c12_3_reg <= c12_2_reg;
            c13_3_reg <= c13_2_reg;
            c22_3_reg <= c22_2_reg;
            c23_3_reg <= c23_2_reg;
            c33_3_reg <= c33_2_reg;
        end
    end

    // stage 4: determinant sum
    logic signed [DETW-1:0] t_a, t_b, t_c;

    assign t_a = (DETW'(ph_a_reg) <<< (DW + 1)) + DETW'(pl_a_reg);
    assign t_b = (DETW'(ph_b_reg) <<< (DW + 1)) + DETW'(pl_b_reg);
    assign t_c = (DETW'(ph_c_reg) <<< (DW + 1)) + DETW'(pl_c_reg);

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            det <= t_a + t_b + t_c;
            c11 <= c11_3_reg;
            c12 <= c12_3_reg;
            c13 <= c13_3_reg;
            c22 <= c22_3_reg;
            c23 <= c23_3_reg;
            c33 <= c33_3_reg;
        end
    end

endmodule

FILE: sv/sym3_lane.sv
`timescale 1ns / 1ps
module sym3_lane #(
    parameter int DW = 32,
    parameter int FB = 24
) (
    input  logic                   clk,
    input  logic [DW+2:0]          en,
    input  logic signed [2*DW:0]   cof,
    input  logic signed [3*DW+2:0] det,
    output logic [DW+1:0]          q,
    output sym3_pkg::lane_flags_t  flags
);
    import sym3_pkg::*;

    localparam int PW   = 2 * DW + 1;
    localparam int DETW = 3 * DW + 3;
    localparam int NW   = PW + 2 * FB;
    localparam int HW   = DW + 2 * FB;
    localparam int MW   = (HW > DETW) ? HW : DETW;
    localparam int NS   = DW + 1;

    // prep: magnitudes, numerator, overflow check
    logic [PW-1:0]   cmag;
    logic [DETW-1:0] dmag;
    logic [NW-1:0]   num;
    logic [MW-1:0]   nhi;

    assign cmag = cof[PW-1] ? PW'(-cof) : PW'(cof);
    assign dmag = det[DETW-1] ? DETW'(-det) : DETW'(det);
    assign num  = {cmag, {(2 * FB){1'b0}}};
    assign nhi  = MW'(num >> (DW + 1));

    logic [DETW-1:0] r_reg   [NS+1];
    logic [DW:0]     q_reg   [NS+1];
    logic [DW:0]     nlo_reg [NS+1];
    logic [DETW-1:0] d_reg   [NS+1];
    lane_flags_t     f_reg   [NS+1];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            r_reg[0]      <= nhi[DETW-1:0];
            q_reg[0]      <= '0;
            nlo_reg[0]    <= num[DW:0];
            d_reg[0]      <= dmag;
            f_reg[0].neg  <= cof[PW-1] ^ det[DETW-1];
            f_reg[0].ovf  <= (nhi >= MW'(dmag));
            f_reg[0].zero <= (det == '0);
        end
    end

    // one quotient bit per stage
    for (genvar k = 1; k <= NS; k++)
    begin : g_step
        logic [DETW:0] t;
        logic          ge;

        assign t  = {r_reg[k-1], nlo_reg[k-1][DW]};
        assign ge = (t >= {1'b0, d_reg[k-1]});

        always_ff @(posedge clk)
        begin
            if (en[k])
            begin
                r_reg[k]   <= ge ? DETW'(t - {1'b0, d_reg[k-1]}) : t[DETW-1:0];
                q_reg[k]   <= {q_reg[k-1][DW-1:0], ge};
                nlo_reg[k] <= nlo_reg[k-1] << 1;
                d_reg[k]   <= d_reg[k-1];
                f_reg[k]   <= f_reg[k-1];
            end
        end
    end

    // round to nearest, ties away from zero
    logic rb;

    assign rb = ({r_reg[NS], 1'b0} >= {1'b0, d_reg[NS]});

    always_ff @(posedge clk)
    begin
        if (en[DW+2])
        begin
            q     <= (DW+2)'(q_reg[NS]) + (DW+2)'(rb);
            flags <= f_reg[NS];
        end
    end

endmodule

FILE: sv/sym3_merge.sv
`timescale 1ns / 1ps
module sym3_merge #(
    parameter int DW = 32
) (
    input  logic                                      clk,
    input  logic                                      en,
    input  logic [sym3_pkg::N_LANES-1:0][DW+1:0]      q,
    input  sym3_pkg::lane_flags_t [sym3_pkg::N_LANES-1:0] flags,
    output logic [sym3_pkg::N_LANES-1:0][DW-1:0]      r,
    output logic                                      singular,
    output logic                                      clipped
);
    import sym3_pkg::*;

    localparam logic [DW+1:0] LIM  = (DW+2)'(1) << (DW - 1);
    localparam logic [DW-1:0] MAXV = {1'b0, {(DW - 1){1'b1}}};
    localparam logic [DW-1:0] MINV = {1'b1, {(DW - 1){1'b0}}};

    logic [N_LANES-1:0]         sat;
    logic [N_LANES-1:0][DW-1:0] val;

    always_comb
    begin
        for (int i = 0; i < N_LANES; i++)
        begin
            sat[i] = flags[i].ovf || (flags[i].neg ? (q[i] > LIM) : (q[i] >= LIM));
            if (flags[0].zero)
                val[i] = '0;
            else if (sat[i])
                val[i] = flags[i].neg ? MINV : MAXV;
            else if (flags[i].neg)
                val[i] = DW'(-q[i]);
            else
                val[i] = q[i][DW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r        <= val;
            singular <= flags[0].zero;
            clipped  <= !flags[0].zero && (|sat);
        end
    end

endmodule

FILE: sv/sym3x3_matrix_inverse_top.sv
`timescale 1ns / 1ps
// Symmetric 3x3 inverse by cofactors, signed fixed point (DATA_WIDTH bits, FRAC_BITS fraction).
// Accepts one transaction per cycle while in_stall is low. Cofactor stages form cofactors and
// determinant, one prep stage follows, then six divider lanes each produce one quotient bit
// per stage over DATA_WIDTH+1 stages, followed by rounding and output stages. Empty stages
// collapse under output stall. Entries round to nearest (ties away from zero) and saturate
// with clipped set; a zero determinant gives zeros with singular set.
module sym3x3_matrix_inverse_top #(
    parameter int DATA_WIDTH = sym3_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = sym3_pkg::FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [DATA_WIDTH-1:0] m11,
    input  logic signed [DATA_WIDTH-1:0] m12,
    input  logic signed [DATA_WIDTH-1:0] m13,
    input  logic signed [DATA_WIDTH-1:0] m22,
    input  logic signed [DATA_WIDTH-1:0] m23,
    input  logic signed [DATA_WIDTH-1:0] m33,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [DATA_WIDTH-1:0] r11,
    output logic signed [DATA_WIDTH-1:0] r12,
    output logic signed [DATA_WIDTH-1:0] r13,
    output logic signed [DATA_WIDTH-1:0] r22,
    output logic signed [DATA_WIDTH-1:0] r23,
    output logic signed [DATA_WIDTH-1:0] r33,
    output logic                         singular,
    output logic                         clipped
);
    import sym3_pkg::*;

    localparam int DW   = DATA_WIDTH;
    localparam int PW   = 2 * DW + 1;
    localparam int DETW = 3 * DW + 3;
    localparam int NST  = DW + 8;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] v_next;
    logic [NST-1:0] ready;

    always_comb
    begin
        ready[NST-1] = !v_reg[NST-1] || !out_stall;
        for (int k = NST - 2; k >= 0; k--)
            ready[k] = !v_reg[k] || ready[k+1];
        if (ready[0])
            v_next[0] = in_valid;
        else
            v_next[0] = v_reg[0];
        for (int k = 1; k < NST; k++)
        begin
            if (ready[k])
                v_next[k] = v_reg[k-1];
            else
                v_next[k] = v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign in_stall  = !ready[0];
    assign out_valid = v_reg[NST-1];

    logic signed [PW-1:0]   cof [N_LANES];
    logic signed [DETW-1:0] det;

    sym3_cof #(.DW(DW)) u_cof (
        .clk (clk),
        .en  (ready[3:0]),
        .a   (m11),
        .b   (m12),
        .c   (m13),
        .e   (m22),
        .f   (m23),
        .g   (m33),
        .c11 (cof[0]),
        .c12 (cof[1]),
        .c13 (cof[2]),
        .c22 (cof[3]),
        .c23 (cof[4]),
        .c33 (cof[5]),
        .det (det)
    );

    logic [N_LANES-1:0][DW+1:0] q;
    lane_flags_t [N_LANES-1:0]  flags;
    logic [N_LANES-1:0][DW-1:0] r;

    for (genvar i = 0; i < N_LANES; i++)
    begin : g_lane
        sym3_lane #(.DW(DW), .FB(FRAC_BITS)) u_lane (
            .clk   (clk),
            .en    (ready[4 +: DW+3]),
            .cof   (cof[i]),
            .det   (det),
            .q     (q[i]),
            .flags (flags[i])
        );
    end

    sym3_merge #(.DW(DW)) u_merge (
        .clk      (clk),
        .en       (ready[NST-1]),
        .q        (q),
        .flags    (flags),
        .r        (r),
        .singular (singular),
        .clipped  (clipped)
    );

    assign r11 = r[0];
    assign r12 = r[1];
    assign r13 = r[2];
    assign r22 = r[3];
    assign r23 = r[4];
    assign r33 = r[5];

endmodule

FILE: sv/sym3_chk.sv
`timescale 1ns / 1ps
`include "sym3x3_matrix_inverse_top_macros.svh"
module sym3_chk #(
    parameter int DW = 32
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 valid,
    input logic                 stall,
    input logic signed [DW-1:0] r11,
    input logic signed [DW-1:0] r12,
    input logic signed [DW-1:0] r13,
    input logic signed [DW-1:0] r22,
    input logic signed [DW-1:0] r23,
    input logic signed [DW-1:0] r33,
    input logic                 singular,
    input logic                 clipped
);
    localparam logic signed [DW-1:0] MAXV = {1'b0, {(DW - 1){1'b1}}};
    localparam logic signed [DW-1:0] MINV = {1'b1, {(DW - 1){1'b0}}};

    logic all_zero;
    logic any_extreme;

    assign all_zero    = r11 == 0 && r12 == 0 && r13 == 0 && r22 == 0 && r23 == 0 && r33 == 0;
    assign any_extreme = r11 == MAXV || r11 == MINV || r12 == MAXV || r12 == MINV ||
                         r13 == MAXV || r13 == MINV || r22 == MAXV || r22 == MINV ||
                         r23 == MAXV || r23 == MINV || r33 == MAXV || r33 == MINV;

    `SYM3_IMPLIES(a_singular_zero, valid && singular, all_zero && !clipped)
    `SYM3_IMPLIES(a_clip_extreme, valid && clipped, any_extreme)
    `SYM3_NEXT(a_valid_hold, valid && stall, valid)
    `SYM3_NEXT(a_data_hold, valid && stall, $stable(r11) && $stable(r33) && $stable(singular))

endmodule

bind sym3x3_matrix_inverse_top sym3_chk #(.DW(DATA_WIDTH)) u_sym3_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid    (out_valid),
    .stall    (out_stall),
    .r11      (r11),
    .r12      (r12),
    .r13      (r13),
    .r22      (r22),
    .r23      (r23),
    .r33      (r33),
    .singular (singular),
    .clipped  (clipped)
);
